// File: rtl/core/gn3_pkg.sv
package gn3_pkg;

    localparam int HashBits = 8;
    localparam int OffsetInt = 5000;
    localparam int OutFrac = 16;
    localparam int OutWidth = 18;
    localparam int CoordWidth = 32;

    typedef logic [HashBits-1:0] hash_t;

    function automatic hash_t lattice_rom(input hash_t idx);
        hash_t r;
        case (idx)
            8'd0: r = 8'h97; 8'd1: r = 8'hA0; 8'd2: r = 8'h89; 8'd3: r = 8'h5B;
            8'd4: r = 8'h5A; 8'd5: r = 8'h0F; 8'd6: r = 8'h83; 8'd7: r = 8'h0D;
            8'd8: r = 8'hC9; 8'd9: r = 8'h5F; 8'd10: r = 8'h60; 8'd11: r = 8'h35;
            8'd12: r = 8'hC2; 8'd13: r = 8'hE8; 8'd14: r = 8'h07; 8'd15: r = 8'hE1;
            8'd16: r = 8'h8C; 8'd17: r = 8'h24; 8'd18: r = 8'h67; 8'd19: r = 8'h1E;
            8'd20: r = 8'h45; 8'd21: r = 8'h8E; 8'd22: r = 8'h08; 8'd23: r = 8'h63;
            8'd24: r = 8'h25; 8'd25: r = 8'hF0; 8'd26: r = 8'h15; 8'd27: r = 8'h0A;
            8'd28: r = 8'h17; 8'd29: r = 8'hBE; 8'd30: r = 8'h06; 8'd31: r = 8'h94;
            8'd32: r = 8'hF7; 8'd33: r = 8'h78; 8'd34: r = 8'hEA; 8'd35: r = 8'h4B;
            8'd36: r = 8'h00; 8'd37: r = 8'h1A; 8'd38: r = 8'hC5; 8'd39: r = 8'h3E;
            8'd40: r = 8'h5E; 8'd41: r = 8'hFC; 8'd42: r = 8'hDB; 8'd43: r = 8'hCB;
            8'd44: r = 8'h75; 8'd45: r = 8'h23; 8'd46: r = 8'h0B; 8'd47: r = 8'h20;
            8'd48: r = 8'h39; 8'd49: r = 8'h75; 8'd50: r = 8'h21; 8'd51: r = 8'h58;
            8'd52: r = 8'hED; 8'd53: r = 8'h95; 8'd54: r = 8'h38; 8'd55: r = 8'h57;
            8'd56: r = 8'hAE; 8'd57: r = 8'h14; 8'd58: r = 8'h7D; 8'd59: r = 8'h88;
            8'd60: r = 8'hAB; 8'd61: r = 8'hA8; 8'd62: r = 8'h44; 8'd63: r = 8'hAF;
            8'd64: r = 8'h4A; 8'd65: r = 8'hA5; 8'd66: r = 8'h47; 8'd67: r = 8'h86;
            8'd68: r = 8'h8B; 8'd69: r = 8'h30; 8'd70: r = 8'h1B; 8'd71: r = 8'hA6;
            8'd72: r = 8'h4D; 8'd73: r = 8'h92; 8'd74: r = 8'h9E; 8'd75: r = 8'hE7;
            8'd76: r = 8'h53; 8'd77: r = 8'h6F; 8'd78: r = 8'hE5; 8'd79: r = 8'h7A;
            8'd80: r = 8'h3C; 8'd81: r = 8'hD3; 8'd82: r = 8'h85; 8'd83: r = 8'hE6;
            8'd84: r = 8'hDC; 8'd85: r = 8'h69; 8'd86: r = 8'h5C; 8'd87: r = 8'h29;
            8'd88: r = 8'h37; 8'd89: r = 8'h2E; 8'd90: r = 8'hF5; 8'd91: r = 8'h28;
            8'd92: r = 8'hF4; 8'd93: r = 8'h66; 8'd94: r = 8'h8F; 8'd95: r = 8'h36;
            8'd96: r = 8'h41; 8'd97: r = 8'h19; 8'd98: r = 8'h3F; 8'd99: r = 8'hA1;
            8'd100: r = 8'h01; 8'd101: r = 8'hD8; 8'd102: r = 8'h50; 8'd103: r = 8'h49;
            8'd104: r = 8'hD1; 8'd105: r = 8'h4C; 8'd106: r = 8'h84; 8'd107: r = 8'hBB;
            8'd108: r = 8'hD0; 8'd109: r = 8'h59; 8'd110: r = 8'h12; 8'd111: r = 8'hA9;
            8'd112: r = 8'hC8; 8'd113: r = 8'hC4; 8'd114: r = 8'h87; 8'd115: r = 8'h82;
            8'd116: r = 8'h74; 8'd117: r = 8'hBC; 8'd118: r = 8'h9F; 8'd119: r = 8'h56;
            8'd120: r = 8'hA4; 8'd121: r = 8'h64; 8'd122: r = 8'h6D; 8'd123: r = 8'hC6;
            8'd124: r = 8'hAD; 8'd125: r = 8'hBA; 8'd126: r = 8'h03; 8'd127: r = 8'h40;
            8'd128: r = 8'h34; 8'd129: r = 8'hD9; 8'd130: r = 8'hE2; 8'd131: r = 8'hFA;
            8'd132: r = 8'h7C; 8'd133: r = 8'h7B; 8'd134: r = 8'h05; 8'd135: r = 8'hCA;
            8'd136: r = 8'h26; 8'd137: r = 8'h93; 8'd138: r = 8'h76; 8'd139: r = 8'h7E;
            8'd140: r = 8'hFF; 8'd141: r = 8'h52; 8'd142: r = 8'h55; 8'd143: r = 8'hD4;
            8'd144: r = 8'hCF; 8'd145: r = 8'hCE; 8'd146: r = 8'h38; 8'd147: r = 8'hE3;
            8'd148: r = 8'h2F; 8'd149: r = 8'h10; 8'd150: r = 8'h3A; 8'd151: r = 8'h11;
            8'd152: r = 8'hB6; 8'd153: r = 8'hBD; 8'd154: r = 8'h1C; 8'd155: r = 8'h2A;
            8'd156: r = 8'hDF; 8'd157: r = 8'hB7; 8'd158: r = 8'hAA; 8'd159: r = 8'hD5;
            8'd160: r = 8'h77; 8'd161: r = 8'hF8; 8'd162: r = 8'h98; 8'd163: r = 8'h02;
            8'd164: r = 8'h2C; 8'd165: r = 8'h9A; 8'd166: r = 8'hA3; 8'd167: r = 8'h46;
            8'd168: r = 8'hDD; 8'd169: r = 8'h99; 8'd170: r = 8'h65; 8'd171: r = 8'h9B;
            8'd172: r = 8'hA7; 8'd173: r = 8'h2B; 8'd174: r = 8'hAC; 8'd175: r = 8'h09;
            8'd176: r = 8'h81; 8'd177: r = 8'h16; 8'd178: r = 8'h27; 8'd179: r = 8'hFD;
            8'd180: r = 8'h13; 8'd181: r = 8'h62; 8'd182: r = 8'h6C; 8'd183: r = 8'h6E;
            8'd184: r = 8'h4F; 8'd185: r = 8'h71; 8'd186: r = 8'hE0; 8'd187: r = 8'hE8;
            8'd188: r = 8'hB2; 8'd189: r = 8'hB9; 8'd190: r = 8'h70; 8'd191: r = 8'h68;
            8'd192: r = 8'hDA; 8'd193: r = 8'hF6; 8'd194: r = 8'h61; 8'd195: r = 8'hE4;
            8'd196: r = 8'hFB; 8'd197: r = 8'h22; 8'd198: r = 8'hF2; 8'd199: r = 8'hC1;
            8'd200: r = 8'hEE; 8'd201: r = 8'hD2; 8'd202: r = 8'h90; 8'd203: r = 8'h0C;
            8'd204: r = 8'hBF; 8'd205: r = 8'hB3; 8'd206: r = 8'hA2; 8'd207: r = 8'hF1;
            8'd208: r = 8'h51; 8'd209: r = 8'h33; 8'd210: r = 8'h91; 8'd211: r = 8'hEB;
            8'd212: r = 8'hF9; 8'd213: r = 8'h0E; 8'd214: r = 8'hEF; 8'd215: r = 8'h6B;
            8'd216: r = 8'h31; 8'd217: r = 8'hC0; 8'd218: r = 8'hD6; 8'd219: r = 8'h1F;
            8'd220: r = 8'hB5; 8'd221: r = 8'hC7; 8'd222: r = 8'h6A; 8'd223: r = 8'h9D;
            8'd224: r = 8'hB8; 8'd225: r = 8'h54; 8'd226: r = 8'hCC; 8'd227: r = 8'hB0;
            8'd228: r = 8'h73; 8'd229: r = 8'h79; 8'd230: r = 8'h32; 8'd231: r = 8'h2D;
            8'd232: r = 8'h7F; 8'd233: r = 8'h04; 8'd234: r = 8'h96; 8'd235: r = 8'hFE;
            8'd236: r = 8'h8A; 8'd237: r = 8'hEC; 8'd238: r = 8'hCD; 8'd239: r = 8'h5D;
            8'd240: r = 8'hDE; 8'd241: r = 8'h72; 8'd242: r = 8'h43; 8'd243: r = 8'h1D;
            8'd244: r = 8'h18; 8'd245: r = 8'h48; 8'd246: r = 8'hF3; 8'd247: r = 8'h8D;
            8'd248: r = 8'h80; 8'd249: r = 8'hC3; 8'd250: r = 8'h4E; 8'd251: r = 8'h42;
            8'd252: r = 8'hD7; 8'd253: r = 8'h3D; 8'd254: r = 8'h9C; 8'd255: r = 8'hB4;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/gn3_lerp.sv
// One pipelined interpolation stage: out = a + round((b - a) * t).
// The product is registered before rounding and the add.
module gn3_lerp #(
    parameter int W = 20,
    parameter int FB = 16
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic        [FB:0]  t,
    output logic signed [W-1:0] y
);
    logic signed [W:0]        diff;
    logic signed [W+FB+2:0]   prod_reg;
    logic signed [W+FB+2:0]   prod_next;
    logic signed [W-1:0]      a_reg;
    logic signed [W+FB+2:0]   rnd;

    assign diff      = W'(b) - W'(a) == 0 ? '0 : $signed({b[W-1], b}) - $signed({a[W-1], a});
    assign prod_next = (W+FB+3)'(diff) * $signed({2'b00, t});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            a_reg    <= a;
        end
    end

    assign rnd = (prod_reg + (W+FB+3)'(1 << (FB - 1))) >>> FB;
    assign y   = W'(a_reg + W'(rnd));
endmodule

// File: rtl/core/gradient_noise_3d.sv
// Channel   Dir  Payload
// s_axis    in   coord_x, coord_y, coord_z
// m_axis    out  noise_value
// One sample per cycle while the output is not stalled.
// The whole pipeline advances when the output register is empty or taken,
// so a stall holds every stage in place and nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module gradient_noise_3d #(
    parameter int FRAC_BITS = 16,
    parameter int HASH_SIZE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // coord_x, coord_y, coord_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // noise_value, zero fill
);
    import gn3_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam int FW = FB + 5;              // fade intermediates (< 16)
    localparam int GW = FB + 4;              // gradient and lerp values
    localparam int NST = 13;
    localparam logic [FB:0] One = (FB+1)'(1) << FB;
    localparam int HM = HASH_SIZE - 1;

    logic [NST-1:0] vld_reg;
    logic           en;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 0: offset and split.
    logic [FB-1:0] f0_reg [3];
    hash_t         c0_reg [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [47:0] off;
                off = {{16{s_axis_tdata[32*i+31]}}, s_axis_tdata[32*i +: 32]}
                      + (48'(OffsetInt) << FB);
                f0_reg[i] <= off[FB-1:0];
                c0_reg[i] <= hash_t'((off >> FB) & 48'(HM));
            end
        end
    end

    // Fade pipeline: four multiply stages per axis, hashing runs alongside.
    logic signed [FW-1:0] fa_reg [3], fb_reg [3], fc_reg [3];
    logic        [FB:0]   ft_reg [3];
    logic        [FB-1:0] f1_reg [3], f2_reg [3], f3_reg [3], f4_reg [3];

    function automatic logic signed [FW-1:0] rmul(input logic [FB-1:0] f,
                                                   input logic signed [FW-1:0] a);
        logic signed [FW+FB+1:0] p;
        p = $signed({2'b00, f}) * (FW+FB+2)'(a);
        p = (p + (FW+FB+2)'(1 << (FB - 1))) >>> FB;
        return FW'(p);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [FW-1:0] sx;
                logic signed [FW-1:0] tt;
                sx = FW'(6) * $signed(FW'({1'b0, f0_reg[i]})) - (FW'(15) << FB);
                fa_reg[i] <= rmul(f0_reg[i], sx) + (FW'(10) << FB);
                f1_reg[i] <= f0_reg[i];
                fb_reg[i] <= rmul(f1_reg[i], fa_reg[i]);
                f2_reg[i] <= f1_reg[i];
                fc_reg[i] <= rmul(f2_reg[i], fb_reg[i]);
                f3_reg[i] <= f2_reg[i];
                tt = rmul(f3_reg[i], fc_reg[i]);
                if (tt < 0)
                    ft_reg[i] <= '0;
                else if (tt > $signed(FW'(One)))
                    ft_reg[i] <= One;
                else
                    ft_reg[i] <= (FB+1)'(tt);
                f4_reg[i] <= f3_reg[i];
            end
        end
    end

    // Hash stages alongside the fade: 1: a0,a1  2: aa..bb  3: corners.
    hash_t h_a_reg [2];
    hash_t h_b_reg [4];
    hash_t h_c_reg [8];
    hash_t cy1_reg, cz1_reg, cz2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_a_reg[0] <= lattice_rom(c0_reg[0]);
            h_a_reg[1] <= lattice_rom(c0_reg[0] + 8'd1);
            cy1_reg    <= c0_reg[1];
            cz1_reg    <= c0_reg[2];
            h_b_reg[0] <= lattice_rom(h_a_reg[0] + cy1_reg);
            h_b_reg[1] <= lattice_rom(h_a_reg[0] + cy1_reg + 8'd1);
            h_b_reg[2] <= lattice_rom(h_a_reg[1] + cy1_reg);
            h_b_reg[3] <= lattice_rom(h_a_reg[1] + cy1_reg + 8'd1);
            cz2_reg    <= cz1_reg;
            for (int k = 0; k < 8; k++)
            begin
                // k bit0: x+1, bit1: y+1, bit2: z+1.
                h_c_reg[k] <= lattice_rom(h_b_reg[{k[0], k[1]}] + cz2_reg
                                          + hash_t'(k[2]));
            end
        end
    end

    // Gradients at the eight corners; hashes held until fade is done.
    hash_t h_d_reg [8];
    logic signed [GW-1:0] g_reg [8];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_d_reg <= h_c_reg;
            for (int k = 0; k < 8; k++)
            begin
                logic [3:0] h;
                logic signed [GW-1:0] px, py, pz, u, v;
                h  = h_d_reg[k][3:0];
                px = $signed(GW'({1'b0, f4_reg[0]})) - (k[0] ? $signed(GW'(One)) : '0);
                py = $signed(GW'({1'b0, f4_reg[1]})) - (k[1] ? $signed(GW'(One)) : '0);
                pz = $signed(GW'({1'b0, f4_reg[2]})) - (k[2] ? $signed(GW'(One)) : '0);
                u  = h < 4'd8 ? px : py;
                if (h < 4'd4)
                    v = py;
                else if (h == 4'd12 || h == 4'd14)
                    v = px;
                else
                    v = pz;
                g_reg[k] <= (h[0] ? -u : u) + (h[1] ? -v : v);
            end
        end
    end

    // Fade values delayed to match each lerp level.
    logic [FB:0] tu_reg, tv1_reg, tv2_reg, tv3_reg;
    logic [FB:0] tw1_reg, tw2_reg, tw3_reg, tw4_reg, tw5_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tu_reg  <= ft_reg[0];
            tv1_reg <= ft_reg[1];
            tv2_reg <= tv1_reg;
            tv3_reg <= tv2_reg;
            tw1_reg <= ft_reg[2];
            tw2_reg <= tw1_reg;
            tw3_reg <= tw2_reg;
            tw4_reg <= tw3_reg;
            tw5_reg <= tw4_reg;
        end
    end

    logic signed [GW-1:0] lx [4];
    logic signed [GW-1:0] ly [2];
    logic signed [GW-1:0] lz;
    logic signed [GW-1:0] lx_reg [4];
    logic signed [GW-1:0] ly_reg [2];
    logic signed [GW-1:0] lz_reg;

    for (genvar j = 0; j < 4; j++)
    begin : g_lx
        gn3_lerp #(.W(GW), .FB(FB)) u_lx (
            .clk(clk), .en(en), .a(g_reg[2*j]), .b(g_reg[2*j+1]),
            .t(tu_reg), .y(lx[j])
        );
    end
    always_ff @(posedge clk)
    begin
        if (en)
            lx_reg <= lx;
    end
    for (genvar j = 0; j < 2; j++)
    begin : g_ly
        gn3_lerp #(.W(GW), .FB(FB)) u_ly (
            .clk(clk), .en(en), .a(lx_reg[2*j]), .b(lx_reg[2*j+1]),
            .t(tv3_reg), .y(ly[j])
        );
    end
    always_ff @(posedge clk)
    begin
        if (en)
            ly_reg <= ly;
    end
    gn3_lerp #(.W(GW), .FB(FB)) u_lz (
        .clk(clk), .en(en), .a(ly_reg[0]), .b(ly_reg[1]), .t(tw5_reg), .y(lz)
    );
    always_ff @(posedge clk)
    begin
        if (en)
            lz_reg <= lz;
    end

    // Output scaling and saturation.
    logic signed [GW+OutFrac:0] rs;
    logic signed [OutWidth-1:0] out_reg;
    always_comb
    begin
        if (FB > OutFrac)
            rs = ((GW+OutFrac+1)'(lz_reg) + (GW+OutFrac+1)'(1 << (FB - OutFrac - 1)))
                 >>> (FB - OutFrac);
        else
            rs = (GW+OutFrac+1)'(lz_reg) <<< (OutFrac - FB);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rs > (GW+OutFrac+1)'(131071))
                out_reg <= 18'sd131071;
            else if (rs < -(GW+OutFrac+1)'(131072))
                out_reg <= -18'sd131072;
            else
                out_reg <= OutWidth'(rs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata  = {6'b0, out_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result lost under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(vld_reg))
        else $error("pipeline moved under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready out of step with output");
endmodule
